// ===== rtl/spph_pkg.sv =====
// Package for the servo position PID block: field widths, operation and
// register codes, saturation limits and helper functions.
// No dependencies.
package spph_pkg;

    // Field and datapath widths
    localparam int OP_W      = 3;
    localparam int POS_W     = 12;
    localparam int ERR_W     = 13;
    localparam int DIF_W     = 14;
    localparam int INTEG_W   = 24;
    localparam int DRIVE_W   = 25;
    localparam int GAIN_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Saturation limits and dead band
    localparam int DRIVE_LIM  = 16777215;
    localparam int INTEG_LIM  = 8388607;
    localparam int DEAD_ERROR = 4;
    localparam int DEAD_INTEG = 1024;

    // Reset value of every history entry
    localparam logic signed [ERR_W-1:0] HIST_RESET = 13'sd2048;

    // Gain reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 8'h08;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 8'h01;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 8'h15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_TARGET  = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTROL_OFF = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_SPEED   = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD_SPEED   = 3'd4;

    // Action carried down the pipeline, resolved at accept time
    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_TICK,
        ACT_TARGET,
        ACT_OFF,
        ACT_SET,
        ACT_ADD
    } act_t;

    // Clamp a widened drive sum to +/- DRIVE_LIM
    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [DRIVE_W+1:0] v
    );
        logic signed [DRIVE_W-1:0] r;
        if (v > DRIVE_LIM)
            r = DRIVE_W'(DRIVE_LIM);
        else if (v < -DRIVE_LIM)
            r = DRIVE_W'(-DRIVE_LIM);
        else
            r = v[DRIVE_W-1:0];
        return r;
    endfunction

    // Clamp a widened integral to +/- INTEG_LIM
    function automatic logic signed [INTEG_W-1:0] sat_integ(
        input logic signed [INTEG_W:0] v
    );
        logic signed [INTEG_W-1:0] r;
        if (v > INTEG_LIM)
            r = INTEG_W'(INTEG_LIM);
        else if (v < -INTEG_LIM)
            r = INTEG_W'(-INTEG_LIM);
        else
            r = v[INTEG_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/spph_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered
// read with read-before-write on an address collision. No dependencies.
module spph_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 7
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/servo_position_pid_hbridge.sv =====
// Servo position PID controller with H-bridge PWM compare outputs.
// Depends on spph_pkg and spph_ram (error history ring).
//
//  channel  | signals                                     | beat taken when
//  ---------+---------------------------------------------+--------------------
//  config   | cfg_we cfg_index cfg_data                   | cfg_we high
//  input    | in_valid in_ready operation position        | in_valid & in_ready
//           | speed_value                                 |
//  output   | out_valid out_ready pwm_reverse pwm_forward | out_valid & out_ready
//           | drive control_on                            |
//
// One beat per cycle while the pipe is not held; a beat passes the history
// read at the accept edge, then integral update, gain products and drive sum,
// each registered. The history ring is a RAM with a registered read: read and
// write of the current slot share the accept cycle, with valid flops standing
// in for the reset value. When the output holds a beat that is not taken, the
// whole pipe holds. Reset is asynchronous, active low, needs no clearing pass.
module servo_position_pid_hbridge #(
    parameter int HISTORY_DEPTH = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [spph_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spph_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [spph_pkg::OP_W-1:0]             operation,
    input  logic [spph_pkg::POS_W-1:0]            position,
    input  logic signed [spph_pkg::DRIVE_W-1:0]   speed_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [spph_pkg::DRIVE_W-1:0]          pwm_reverse,
    output logic [spph_pkg::DRIVE_W-1:0]          pwm_forward,
    output logic signed [spph_pkg::DRIVE_W-1:0]   drive,
    output logic                                  control_on
);

    import spph_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // Gains
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;

    // Front state, updated at accept
    logic [POS_W-1:0]         target_reg;
    logic                     en_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [HISTORY_DEPTH-1:0] hvalid_reg;

    // Pipeline control
    logic advance;
    logic accept;

    // Stage 0 decode
    act_t                     act_in;
    logic                     en_next;
    logic [POS_W-1:0]         target_next;
    logic [PTR_W-1:0]         ptr_next;
    logic [HISTORY_DEPTH-1:0] hvalid_next;
    logic signed [ERR_W-1:0]  err_in;
    logic                     hist_we;
    logic [ERR_W-1:0]         hist_rdata;

    // Stage 1
    logic                      s1_valid_reg;
    act_t                      s1_act_reg;
    logic                      s1_en_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [DRIVE_W-1:0] s1_speed_reg;
    logic                      s1_hvalid_reg;
    logic signed [ERR_W-1:0]   s1_hist;
    logic signed [DIF_W-1:0]   s1_dif;
    logic signed [ERR_W-1:0]   s1_half;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    // Stage 2
    logic                      s2_valid_reg;
    act_t                      s2_act_reg;
    logic                      s2_en_reg;
    logic signed [ERR_W-1:0]   s2_err_reg;
    logic signed [DIF_W-1:0]   s2_dif_reg;
    logic signed [DRIVE_W-1:0] s2_speed_reg;
    logic signed [ERR_W+GAIN_W:0]   s2_pe;
    logic signed [DIF_W+GAIN_W:0]   s2_dd;
    logic signed [INTEG_W+GAIN_W:0] s2_ii;
    logic                           s2_dead;

    // Stage 3
    logic                           s3_valid_reg;
    act_t                           s3_act_reg;
    logic                           s3_en_reg;
    logic signed [DRIVE_W-1:0]      s3_speed_reg;
    logic signed [ERR_W+GAIN_W:0]   s3_pe_reg;
    logic signed [DIF_W+GAIN_W:0]   s3_dd_reg;
    logic signed [INTEG_W+GAIN_W:0] s3_ii_reg;
    logic                           s3_dead_reg;
    logic signed [DRIVE_W+1:0]      s3_sum;
    logic signed [DRIVE_W+1:0]      s3_add;
    logic signed [DRIVE_W-1:0]      drive_reg;
    logic signed [DRIVE_W-1:0]      drive_next;

    // Output
    logic                      out_valid_reg;
    logic                      out_en_reg;
    logic signed [DRIVE_W-1:0] mag;

    // Handshake: the pipe moves unless a finished beat waits
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_i_reg <= GAIN_I_RESET;
            gain_d_reg <= GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Stage 0: decode the beat and update the front state
    always_comb
    begin
        act_in      = ACT_NOP;
        en_next     = en_reg;
        target_next = target_reg;
        unique case (operation)
            OP_TICK:
            begin
                act_in = en_reg ? ACT_TICK : ACT_NOP;
            end
            OP_SET_TARGET:
            begin
                act_in      = ACT_TARGET;
                en_next     = 1'b1;
                target_next = position;
            end
            OP_CONTROL_OFF:
            begin
                act_in  = ACT_OFF;
                en_next = 1'b0;
            end
            OP_SET_SPEED: act_in = ACT_SET;
            OP_ADD_SPEED: act_in = ACT_ADD;
            default:      act_in = ACT_NOP;
        endcase
    end

    assign err_in  = $signed({1'b0, target_reg}) - $signed({1'b0, position});
    assign hist_we = accept && (act_in == ACT_TICK);

    always_comb
    begin
        ptr_next    = ptr_reg;
        hvalid_next = hvalid_reg;
        if (hist_we)
        begin
            hvalid_next[ptr_reg] = 1'b1;
            if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                ptr_next = '0;
            else
                ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= POS_W'(2048);
            en_reg     <= 1'b0;
            ptr_reg    <= '0;
            hvalid_reg <= '0;
        end
        else if (accept)
        begin
            target_reg <= target_next;
            en_reg     <= en_next;
            ptr_reg    <= ptr_next;
            hvalid_reg <= hvalid_next;
        end
    end

    // Error history ring: old entry read, new error written, same slot
    spph_ram #(
        .WIDTH (ERR_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (err_in),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (hist_rdata)
    );

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_act_reg   <= ACT_NOP;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s1_act_reg   <= act_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_en_reg     <= en_next;
            s1_err_reg    <= err_in;
            s1_speed_reg  <= speed_value;
            s1_hvalid_reg <= hvalid_reg[ptr_reg];
        end
    end

    // Stage 1: derivative and integral of half-errors
    assign s1_hist = s1_hvalid_reg ? $signed(hist_rdata) : HIST_RESET;
    assign s1_dif  = DIF_W'(s1_err_reg) - DIF_W'(s1_hist);
    // halve toward zero
    assign s1_half = (s1_err_reg + $signed({{(ERR_W-1){1'b0}}, s1_err_reg[ERR_W-1]})) >>> 1;

    always_comb
    begin
        integ_next = integ_reg;
        if (advance && s1_valid_reg)
        begin
            unique case (s1_act_reg)
                ACT_TARGET: integ_next = '0;
                ACT_TICK:   integ_next = sat_integ((INTEG_W+1)'(integ_reg)
                                                   + (INTEG_W+1)'(s1_half));
                default:    integ_next = integ_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            s2_valid_reg <= 1'b0;
            s2_act_reg   <= ACT_NOP;
        end
        else
        begin
            integ_reg <= integ_next;
            if (advance)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_act_reg   <= s1_act_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_en_reg    <= s1_en_reg;
            s2_err_reg   <= s1_err_reg;
            s2_dif_reg   <= s1_dif;
            s2_speed_reg <= s1_speed_reg;
        end
    end

    // Stage 2: gain products and dead band test
    assign s2_pe = $signed({1'b0, gain_p_reg}) * s2_err_reg;
    assign s2_dd = $signed({1'b0, gain_d_reg}) * s2_dif_reg;
    assign s2_ii = $signed({1'b0, gain_i_reg}) * integ_reg;
    assign s2_dead = (s2_err_reg < DEAD_ERROR) && (s2_err_reg > -DEAD_ERROR)
                  && (integ_reg < DEAD_INTEG) && (integ_reg > -DEAD_INTEG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_act_reg   <= ACT_NOP;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_act_reg   <= s2_act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_en_reg    <= s2_en_reg;
            s3_speed_reg <= s2_speed_reg;
            s3_pe_reg    <= s2_pe;
            s3_dd_reg    <= s2_dd;
            s3_ii_reg    <= s2_ii;
            s3_dead_reg  <= s2_dead;
        end
    end

    // Stage 3: drive sum, direct speed writes, saturation
    assign s3_sum = (DRIVE_W+2)'(s3_pe_reg) + (DRIVE_W+2)'(s3_dd_reg)
                  + (DRIVE_W+2)'(s3_ii_reg >>> 8);
    assign s3_add = (DRIVE_W+2)'(drive_reg) + (DRIVE_W+2)'(s3_speed_reg);

    always_comb
    begin
        unique case (s3_act_reg)
            ACT_TICK:   drive_next = s3_dead_reg ? '0 : sat_drive(s3_sum);
            ACT_OFF:    drive_next = '0;
            ACT_SET:    drive_next = sat_drive((DRIVE_W+2)'(s3_speed_reg));
            ACT_ADD:    drive_next = sat_drive(s3_add);
            default:    drive_next = drive_reg;
        endcase
    end

    // Drive state doubles as the output drive register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_en_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                drive_reg  <= drive_next;
                out_en_reg <= s3_en_reg;
            end
        end
    end

    // PWM compare split by drive sign
    assign mag         = -drive_reg;
    assign pwm_forward = drive_reg[DRIVE_W-1] ? '0 : {drive_reg[DRIVE_W-2:0], 1'b0};
    assign pwm_reverse = drive_reg[DRIVE_W-1] ? {mag[DRIVE_W-2:0], 1'b0} : '0;
    assign drive       = drive_reg;
    assign control_on  = out_en_reg;
    assign out_valid   = out_valid_reg;

endmodule

// ===== tb/servo_position_pid_hbridge_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_position_pid_hbridge: drives PID events, tracks the
// loop state in a local predictor and compares every PWM/drive beat in order.
// Depends on spph_pkg and the servo_position_pid_hbridge RTL.
module servo_position_pid_hbridge_tb;

    import spph_pkg::*;

    localparam int HIST_DEPTH = 7;
    localparam int POS_MAX    = (1 << POS_W) - 1;
    localparam int GAIN_MAX   = (1 << GAIN_W) - 1;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_ADD_SPEED + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = {OP_W{1'b1}};
    localparam int RX_HOLD_CYCLES = 80;
    localparam int MAX_PRINTED    = 100;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // One expected output beat
    typedef struct {
        logic [DRIVE_W-1:0]        rev;
        logic [DRIVE_W-1:0]        fwd;
        logic signed [DRIVE_W-1:0] drv;
        logic                      on;
    } hbridge_out_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [GAIN_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [OP_W-1:0]            operation = '0;
    logic [POS_W-1:0]           position = '0;
    logic signed [DRIVE_W-1:0]  speed_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [DRIVE_W-1:0]         pwm_reverse;
    logic [DRIVE_W-1:0]         pwm_forward;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       control_on;

    // Predicted loop state and gains
    int  kp, ki, kd;
    int  servo_target;
    int  err_ring [HIST_DEPTH];
    int  ring_slot;
    int  err_integral;
    int  drive_now;
    bit  loop_on;

    hbridge_out_t pending_outs [$];
    int  error_count = 0;
    int  beat_count = 0;
    bit  idle_on = 1'b1;
    bit  rx_hold_on = 1'b0;
    int  rx_stall_left = 0;
    event rx_hold_start;

    servo_position_pid_hbridge #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .position    (position),
        .speed_value (speed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pwm_reverse (pwm_reverse),
        .pwm_forward (pwm_forward),
        .drive       (drive),
        .control_on  (control_on)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Advance the predicted loop by one accepted event and queue its output beat
    task automatic predict_servo_event(
        input logic [OP_W-1:0]           op,
        input logic [POS_W-1:0]          pos,
        input logic signed [DRIVE_W-1:0] sv
    );
        int err;
        int diff;
        int half;
        longint acc;
        hbridge_out_t exp_out;
        case (op)
            OP_TICK:
            begin
                if (loop_on)
                begin
                    err = servo_target - int'(pos);
                    diff = err - err_ring[ring_slot];
                    err_ring[ring_slot] = err;
                    ring_slot = (ring_slot == HIST_DEPTH - 1) ? 0 : ring_slot + 1;
                    // int division truncates toward zero
                    half = err / 2;
                    err_integral = int'(clamp_sym(longint'(err_integral) + half, INTEG_LIM));
                    if (err < DEAD_ERROR && err > -DEAD_ERROR &&
                        err_integral < DEAD_INTEG && err_integral > -DEAD_INTEG)
                        drive_now = 0;
                    else
                    begin
                        acc = longint'(kp) * err + longint'(kd) * diff +
                              ((longint'(ki) * err_integral) >>> 8);
                        drive_now = int'(clamp_sym(acc, DRIVE_LIM));
                    end
                end
            end
            OP_SET_TARGET:
            begin
                servo_target = int'(pos);
                err_integral = 0;
                loop_on = 1'b1;
            end
            OP_CONTROL_OFF:
            begin
                drive_now = 0;
                loop_on = 1'b0;
            end
            OP_SET_SPEED:
                drive_now = int'(clamp_sym(longint'(sv), DRIVE_LIM));
            OP_ADD_SPEED:
                drive_now = int'(clamp_sym(longint'(drive_now) + longint'(sv), DRIVE_LIM));
            default:
                ;
        endcase
        if (drive_now < 0)
        begin
            exp_out.rev = DRIVE_W'(-drive_now * 2);
            exp_out.fwd = '0;
        end
        else
        begin
            exp_out.rev = '0;
            exp_out.fwd = DRIVE_W'(drive_now * 2);
        end
        exp_out.drv = DRIVE_W'(drive_now);
        exp_out.on  = loop_on;
        pending_outs.push_back(exp_out);
    endtask

    // Offer one event beat, with an optional idle burst before it
    task automatic send_event(
        input logic [OP_W-1:0]           op,
        input logic [POS_W-1:0]          pos,
        input logic signed [DRIVE_W-1:0] sv
    );
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid    <= 1'b0;
            operation   <= OP_W'($urandom);
            position    <= POS_W'($urandom);
            speed_value <= DRIVE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        position    <= pos;
        speed_value <= sv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_servo_event(op, pos, sv);
    endtask

    // Random event, mostly ticks, with positions often near the current target so the loop stays busy
    task automatic pick_event(
        output logic [OP_W-1:0]           op,
        output logic [POS_W-1:0]          pos,
        output logic signed [DRIVE_W-1:0] sv
    );
        int sel;
        int near;
        sel = $urandom_range(0, 99);
        if (sel < 68)
            op = OP_TICK;
        else if (sel < 78)
            op = OP_SET_TARGET;
        else if (sel < 82)
            op = OP_CONTROL_OFF;
        else if (sel < 89)
            op = OP_SET_SPEED;
        else if (sel < 98)
            op = OP_ADD_SPEED;
        else
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            near = servo_target + int'($urandom_range(0, 10)) - 5;
            if (near < 0)
                near = 0;
            if (near > POS_MAX)
                near = POS_MAX;
            pos = POS_W'(near);
        end
        else if (sel < 5)
            pos = $urandom_range(0, 1) ? POS_W'(POS_MAX) : '0;
        else
            pos = POS_W'($urandom_range(0, POS_MAX));

        sel = $urandom_range(0, 19);
        if (sel < 3)
            sv = $urandom_range(0, 1) ? DRIVE_W'(DRIVE_LIM) : DRIVE_W'(-DRIVE_LIM);
        else if (sel < 10)
            sv = DRIVE_W'(int'($urandom_range(0, 2000)) - 1000);
        else
            sv = DRIVE_W'(int'($urandom_range(0, 2 * DRIVE_LIM)) - DRIVE_LIM);
    endtask

    // Stop offering events and let every outstanding beat come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= GAIN_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_GAIN_P: kp = val;
            CFG_GAIN_I: ki = val;
            CFG_GAIN_D: kd = val;
            default:    ;
        endcase
    endtask

    task automatic set_gains(input int p, input int i, input int d);
        drain();
        write_gain(CFG_GAIN_P, p);
        write_gain(CFG_GAIN_I, i);
        write_gain(CFG_GAIN_D, d);
    endtask

    // ---------------------------------------------------------------- tests

    // Field extremes, every operation and the corner cases, at reset gains
    task automatic directed_events();
        send_event(OP_TICK, '0, '0);                    // tick while off: no change
        for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            send_event(OP_W'(k), POS_W'($urandom), DRIVE_W'($urandom));
        send_event(OP_SET_SPEED, '0, DRIVE_W'(DRIVE_LIM));
        send_event(OP_ADD_SPEED, '0, DRIVE_W'(DRIVE_LIM));      // saturate high
        send_event(OP_SET_SPEED, '0, DRIVE_W'(-DRIVE_LIM));
        send_event(OP_ADD_SPEED, '0, DRIVE_W'(-DRIVE_LIM));     // saturate low
        send_event(OP_ADD_SPEED, POS_W'(POS_MAX), DRIVE_W'(1));
        send_event(OP_SET_TARGET, POS_W'(POS_MAX), '0);         // enable, drive kept
        send_event(OP_TICK, '0, '0);                            // largest positive error
        send_event(OP_TICK, POS_W'(POS_MAX), '0);               // zero error, integral live
        send_event(OP_SET_TARGET, '0, '0);                      // integral cleared
        send_event(OP_TICK, POS_W'(POS_MAX), '0);               // largest negative error
        send_event(OP_TICK, POS_W'(3), '0);                     // odd negative half-error
        send_event(OP_SET_TARGET, POS_W'(100), '0);
        send_event(OP_TICK, POS_W'(98), '0);                    // inside dead band
        send_event(OP_TICK, POS_W'(103), '0);                   // dead band edge
        send_event(OP_TICK, POS_W'(96), '0);                    // just outside
        send_event(OP_SET_SPEED, '0, DRIVE_W'(12345));          // applied while enabled
        send_event(OP_ADD_SPEED, '0, DRIVE_W'(-20000));
        send_event(OP_TICK, POS_W'(100), '0);                   // tick overrides
        send_event(OP_CONTROL_OFF, '0, '0);
        send_event(OP_TICK, '0, '0);
    endtask

    task automatic random_phase(input int p, input int i, input int d, input int n_events);
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          pos;
        logic signed [DRIVE_W-1:0] sv;
        set_gains(p, i, d);
        repeat (n_events)
        begin
            pick_event(op, pos, sv);
            send_event(op, pos, sv);
        end
    endtask

    // Long run of large negative errors so the integral term grows large
    task automatic integral_windup();
        set_gains($urandom_range(0, GAIN_MAX), GAIN_MAX, $urandom_range(0, GAIN_MAX));
        send_event(OP_SET_TARGET, '0, '0);
        repeat (300)
            send_event(OP_TICK, POS_W'($urandom_range(POS_MAX - 3, POS_MAX)), '0);
        repeat (20)
            send_event(OP_TICK, POS_W'($urandom_range(0, POS_MAX)), '0);
    endtask

    // Receiver holds off while events keep coming, so the pipe fills and stalls
    task automatic output_hold_off();
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          pos;
        logic signed [DRIVE_W-1:0] sv;
        drain();
        send_event(OP_SET_TARGET, POS_W'($urandom_range(0, POS_MAX)), '0);
        -> rx_hold_start;
        repeat (40)
        begin
            pick_event(op, pos, sv);
            send_event(op, pos, sv);
        end
    endtask

    // Last stretch with no idling on either side
    task automatic back_to_back();
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          pos;
        logic signed [DRIVE_W-1:0] sv;
        drain();
        idle_on = 1'b0;
        repeat (160)
        begin
            pick_event(op, pos, sv);
            send_event(op, pos, sv);
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        kp = int'(GAIN_P_RESET);
        ki = int'(GAIN_I_RESET);
        kd = int'(GAIN_D_RESET);
        servo_target = 2048;
        for (int k = 0; k < HIST_DEPTH; k++)
            err_ring[k] = int'(HIST_RESET);
        ring_slot = 0;
        err_integral = 0;
        drive_now = 0;
        loop_on = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed_events();
        random_phase(int'(GAIN_P_RESET), int'(GAIN_I_RESET), int'(GAIN_D_RESET), 160);
        random_phase(0, 0, 0, 160);
        random_phase(GAIN_MAX, GAIN_MAX, GAIN_MAX, 160);
        random_phase($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                     $urandom_range(0, GAIN_MAX), 160);
        random_phase(GAIN_MAX, 0, $urandom_range(0, 40), 160);
        integral_windup();
        output_hold_off();
        back_to_back();
        drain();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // Long hold-off, counted here
    initial
    begin
        forever
        begin
            @(rx_hold_start);
            rx_hold_on = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold_on = 1'b0;
        end
    end

    // Ready with random stall bursts while idle_on is set
    always @(posedge clk)
    begin
        if (rx_hold_on)
            out_ready <= 1'b0;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        hbridge_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outs.size() == 0)
                flag_error($sformatf("output beat %0d with nothing expected (drive %0d)",
                                     beat_count, drive));
            else
            begin
                want = pending_outs.pop_front();
                if (pwm_reverse !== want.rev)
                    flag_error($sformatf("beat %0d pwm_reverse got %0d want %0d",
                                         beat_count, pwm_reverse, want.rev));
                if (pwm_forward !== want.fwd)
                    flag_error($sformatf("beat %0d pwm_forward got %0d want %0d",
                                         beat_count, pwm_forward, want.fwd));
                if (drive !== want.drv)
                    flag_error($sformatf("beat %0d drive got %0d want %0d",
                                         beat_count, drive, want.drv));
                if (control_on !== want.on)
                    flag_error($sformatf("beat %0d control_on got %0b want %0b",
                                         beat_count, control_on, want.on));
            end
            beat_count++;
        end
    end

endmodule
